[hw/rtl/fues_pkg.sv]
// Shared codes, types and micro-operation table for the flash sequencer.
package fues_pkg;

   localparam int DEF_ADDR_WIDTH = 32;
   localparam int DEF_MAX_BLOCKS = 1024;

   localparam int BUS_ADDR_W    = 32;
   localparam int WORD_W        = 16;
   localparam int MODE_W        = 2;
   localparam int OP_W          = 2;
   localparam int BLOCK_TOTAL_W = 11;
   localparam int STRIDE_W      = 25;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int STEP_W        = 3;
   localparam int KIND_W        = 3;
   localparam int STATUS_READY_BIT = 7;

   // input item modes
   localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STATUS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SOURCE = 2'd2;

   // bus operations
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SRC   = 2'd2;
   localparam logic [OP_W-1:0] OP_DONE  = 2'd3;

   // sequence phases
   localparam logic [2:0] PHASE_IDLE   = 3'd0;
   localparam logic [2:0] PHASE_UNLOCK = 3'd1;
   localparam logic [2:0] PHASE_ERASE  = 3'd2;
   localparam logic [2:0] PHASE_PROG   = 3'd3;
   localparam logic [2:0] PHASE_DONE   = 3'd4;

   // expected reply
   localparam logic [1:0] AWAIT_NOTHING = 2'd0;
   localparam logic [1:0] AWAIT_STATUS  = 2'd1;
   localparam logic [1:0] AWAIT_SOURCE  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FLASH_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_TOTAL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_STRIDE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_BASE  = 2'd3;

   localparam logic [BUS_ADDR_W-1:0]    RESET_FLASH_BASE   = 32'h501B_0000;
   localparam logic [BLOCK_TOTAL_W-1:0] RESET_BLOCK_TOTAL  = 11'd74;
   localparam logic [STRIDE_W-1:0]      RESET_BLOCK_STRIDE = 25'd32768;
   localparam logic [BUS_ADDR_W-1:0]    RESET_SOURCE_BASE  = 32'h0010_0000;

   // flash commands
   localparam logic [WORD_W-1:0] CMD_READ_ARRAY = 16'hFFFF;
   localparam logic [WORD_W-1:0] CMD_ERASE      = 16'h2020;
   localparam logic [WORD_W-1:0] CMD_PROGRAM    = 16'h4040;
   localparam logic [WORD_W-1:0] CMD_UNLOCK     = 16'h6060;
   localparam logic [WORD_W-1:0] CMD_STATUS     = 16'h7070;
   localparam logic [WORD_W-1:0] CMD_CONFIRM    = 16'hD0D0;

   // queued command kinds, each a fixed run of bus words
   localparam logic [KIND_W-1:0] KIND_POLL        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BLOCK       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ARRAY_BLOCK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FETCH       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ARRAY_FETCH = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FINISH      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_PROGRAM     = 3'd6;

   // address and data selects of one bus word
   localparam logic [1:0] ASEL_BLOCK = 2'd0;
   localparam logic [1:0] ASEL_AUX   = 2'd1;
   localparam logic [1:0] ASEL_ZERO  = 2'd2;

   localparam logic [2:0] DSEL_ZERO    = 3'd0;
   localparam logic [2:0] DSEL_ITEM    = 3'd1;
   localparam logic [2:0] DSEL_CONFIRM = 3'd2;
   localparam logic [2:0] DSEL_STATUS  = 3'd3;
   localparam logic [2:0] DSEL_ARRAY   = 3'd4;
   localparam logic [2:0] DSEL_PROGRAM = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [BUS_ADDR_W-1:0] blk_addr;
      logic [BUS_ADDR_W-1:0] aux_addr;
      logic [WORD_W-1:0]     data;
   } cmd_entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      asel;
      logic [2:0]      dsel;
      logic            last;
   } uop_type;

   function automatic uop_type fues_uop(input logic [KIND_W-1:0] kind,
                                        input logic [STEP_W-1:0] step);
      uop_type u;
      u = '{OP_DONE, ASEL_ZERO, DSEL_ZERO, 1'b1};
      unique case (kind)
         KIND_POLL: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_STATUS, 1'b0};
               default: u = '{OP_READ, ASEL_BLOCK, DSEL_ZERO, 1'b1};
            endcase
         end
         KIND_BLOCK: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_ITEM, 1'b0};
               3'd1:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_CONFIRM, 1'b0};
               3'd2:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_STATUS, 1'b0};
               default: u = '{OP_READ, ASEL_BLOCK, DSEL_ZERO, 1'b1};
            endcase
         end
         KIND_ARRAY_BLOCK: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_ARRAY, 1'b0};
               3'd1:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_ITEM, 1'b0};
               3'd2:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_CONFIRM, 1'b0};
               3'd3:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_STATUS, 1'b0};
               default: u = '{OP_READ, ASEL_BLOCK, DSEL_ZERO, 1'b1};
            endcase
         end
         KIND_FETCH: begin
            u = '{OP_SRC, ASEL_AUX, DSEL_ZERO, 1'b1};
         end
         KIND_ARRAY_FETCH: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_ARRAY, 1'b0};
               default: u = '{OP_SRC, ASEL_AUX, DSEL_ZERO, 1'b1};
            endcase
         end
         KIND_FINISH: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_ARRAY, 1'b0};
               default: u = '{OP_DONE, ASEL_ZERO, DSEL_ZERO, 1'b1};
            endcase
         end
         KIND_PROGRAM: begin
            unique case (step)
               3'd0:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_PROGRAM, 1'b0};
               3'd1:    u = '{OP_WRITE, ASEL_AUX, DSEL_ITEM, 1'b0};
               3'd2:    u = '{OP_WRITE, ASEL_BLOCK, DSEL_STATUS, 1'b0};
               default: u = '{OP_READ, ASEL_BLOCK, DSEL_ZERO, 1'b1};
            endcase
         end
         default: u = '{OP_DONE, ASEL_ZERO, DSEL_ZERO, 1'b1};
      endcase
      return u;
   endfunction

endpackage

[hw/rtl/fues_front.sv]
// Front end: registers, sequence state and classification of incoming words.
module fues_front #(
   parameter int ADDR_WIDTH = fues_pkg::DEF_ADDR_WIDTH,
   parameter int MAX_BLOCKS = fues_pkg::DEF_MAX_BLOCKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fues_pkg::MODE_W-1:0]      req_mode,
   input  logic [fues_pkg::WORD_W-1:0]      req_reply_word,
   input  logic                             csr_write_enable,
   input  logic [fues_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fues_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic                             push_valid,
   output fues_pkg::cmd_entry_type          push_entry,
   input  logic                             queue_full
);
   import fues_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CNT_W  = (IDX_W > BLOCK_TOTAL_W) ? IDX_W : BLOCK_TOTAL_W;
   localparam int PROD_W = IDX_W + STRIDE_W;
   localparam int MUL_W  = (PROD_W > BUS_ADDR_W) ? PROD_W : BUS_ADDR_W;
   localparam logic [BUS_ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= BUS_ADDR_W) ?
      {BUS_ADDR_W{1'b1}} : BUS_ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   logic [BUS_ADDR_W-1:0]    flash_base_ff;
   logic [BLOCK_TOTAL_W-1:0] block_total_ff;
   logic [STRIDE_W-1:0]      block_stride_ff;
   logic [BUS_ADDR_W-1:0]    source_base_ff;

   logic [2:0]            phase_ff, phase_in;
   logic [1:0]            awaiting_ff, awaiting_in;
   logic [IDX_W-1:0]      block_index_ff, block_index_in;
   logic [BUS_ADDR_W-1:0] word_address_ff, word_address_in;
   logic [BUS_ADDR_W-1:0] source_address_ff, source_address_in;
   logic [BUS_ADDR_W-1:0] cur_off_ff, nxt_off_ff;
   logic                  stale_ff, stale_in;

   logic [STRIDE_W-1:0]   stride_eff;
   logic [MUL_W-1:0]      mul_cur, mul_nxt;
   logic [CNT_W-1:0]      total_ext, blocks_eff;
   logic [IDX_W-1:0]      idx_inc, idx_prog;
   logic [BUS_ADDR_W-1:0] base_m, src_m, cur_addr, end_addr;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff   <= RESET_FLASH_BASE;
         block_total_ff  <= RESET_BLOCK_TOTAL;
         block_stride_ff <= RESET_BLOCK_STRIDE;
         source_base_ff  <= RESET_SOURCE_BASE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FLASH_BASE:   flash_base_ff   <= csr_write_data;
            REG_BLOCK_TOTAL:  block_total_ff  <= csr_write_data[BLOCK_TOTAL_W-1:0];
            REG_BLOCK_STRIDE: block_stride_ff <= csr_write_data[STRIDE_W-1:0];
            REG_SOURCE_BASE:  source_base_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // drop bit 0 of the stride; a stride of zero or one acts as two
   assign stride_eff = (block_stride_ff[STRIDE_W-1:1] == '0) ? STRIDE_W'(2) :
                       {block_stride_ff[STRIDE_W-1:1], 1'b0};

   assign mul_cur = MUL_W'(block_index_ff) * MUL_W'(stride_eff);
   assign mul_nxt = mul_cur + MUL_W'(stride_eff);

   // block offsets are registered and follow the index in the next cycle
   always_ff @(posedge clock) begin
      cur_off_ff <= mul_cur[BUS_ADDR_W-1:0];
      nxt_off_ff <= mul_nxt[BUS_ADDR_W-1:0];
   end

   assign total_ext  = CNT_W'(block_total_ff);
   assign blocks_eff = (total_ext == '0) ? CNT_W'(1) :
                       (total_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_ext;

   assign base_m   = flash_base_ff & ADDR_MASK;
   assign src_m    = source_base_ff & ADDR_MASK;
   assign cur_addr = (flash_base_ff + cur_off_ff) & ADDR_MASK;
   assign end_addr = (flash_base_ff + nxt_off_ff) & ADDR_MASK;
   assign idx_inc  = block_index_ff + 1'b1;
   assign idx_prog = (word_address_ff == end_addr) ? idx_inc : block_index_ff;

   assign req_ready = !queue_full && !stale_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in          = phase_ff;
      awaiting_in       = awaiting_ff;
      block_index_in    = block_index_ff;
      word_address_in   = word_address_ff;
      source_address_in = source_address_ff;
      push_valid        = 1'b0;
      push_entry        = '{KIND_POLL, cur_addr, word_address_ff, req_reply_word};
      if (accept) begin
         unique case (req_mode)
            MODE_START: begin
               if (phase_ff == PHASE_IDLE || phase_ff == PHASE_DONE) begin
                  phase_in       = PHASE_UNLOCK;
                  block_index_in = '0;
                  awaiting_in    = AWAIT_STATUS;
                  push_valid     = 1'b1;
                  push_entry     = '{KIND_BLOCK, base_m, word_address_ff, CMD_UNLOCK};
               end
            end
            MODE_STATUS: begin
               if (awaiting_ff == AWAIT_STATUS) begin
                  if (!req_reply_word[STATUS_READY_BIT]) begin
                     push_valid = 1'b1;
                  end else if (phase_ff == PHASE_UNLOCK || phase_ff == PHASE_ERASE) begin
                     push_valid = 1'b1;
                     if (CNT_W'(idx_inc) < blocks_eff) begin
                        block_index_in = idx_inc;
                        push_entry = '{KIND_BLOCK, end_addr, word_address_ff,
                                       (phase_ff == PHASE_UNLOCK) ? CMD_UNLOCK : CMD_ERASE};
                     end else begin
                        block_index_in = '0;
                        if (phase_ff == PHASE_UNLOCK) begin
                           phase_in   = PHASE_ERASE;
                           push_entry = '{KIND_ARRAY_BLOCK, base_m, word_address_ff, CMD_ERASE};
                        end else begin
                           phase_in          = PHASE_PROG;
                           word_address_in   = base_m;
                           source_address_in = src_m;
                           awaiting_in       = AWAIT_SOURCE;
                           push_entry = '{KIND_ARRAY_FETCH, base_m, src_m, req_reply_word};
                        end
                     end
                  end else if (phase_ff == PHASE_PROG) begin
                     push_valid     = 1'b1;
                     block_index_in = idx_prog;
                     if (CNT_W'(idx_prog) >= blocks_eff) begin
                        phase_in    = PHASE_DONE;
                        awaiting_in = AWAIT_NOTHING;
                        push_entry  = '{KIND_FINISH, base_m, source_address_ff, req_reply_word};
                     end else begin
                        awaiting_in = AWAIT_SOURCE;
                        push_entry  = '{KIND_FETCH, cur_addr, source_address_ff, req_reply_word};
                     end
                  end else begin
                     awaiting_in = AWAIT_NOTHING;
                  end
               end
            end
            MODE_SOURCE: begin
               if (awaiting_ff == AWAIT_SOURCE) begin
                  push_valid        = 1'b1;
                  push_entry        = '{KIND_PROGRAM, cur_addr, word_address_ff, req_reply_word};
                  word_address_in   = (word_address_ff + BUS_ADDR_W'(2)) & ADDR_MASK;
                  source_address_in = (source_address_ff + BUS_ADDR_W'(2)) & ADDR_MASK;
                  awaiting_in       = AWAIT_STATUS;
               end
            end
            default: ;
         endcase
      end
   end

   // hold the input while the block offsets catch up with a new index or stride
   assign stale_in = (block_index_in != block_index_ff) ||
                     (csr_write_enable && csr_index == REG_BLOCK_STRIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_IDLE;
         awaiting_ff       <= AWAIT_NOTHING;
         block_index_ff    <= '0;
         word_address_ff   <= '0;
         source_address_ff <= '0;
         stale_ff          <= 1'b1;
      end else begin
         phase_ff          <= phase_in;
         awaiting_ff       <= awaiting_in;
         block_index_ff    <= block_index_in;
         word_address_ff   <= word_address_in;
         source_address_ff <= source_address_in;
         stale_ff          <= stale_in;
      end
   end

endmodule

[hw/rtl/fues_queue.sv]
// Short command queue between the front and back ends.
module fues_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  fues_pkg::cmd_entry_type push_entry,
   output logic                    full,
   output logic                    head_valid,
   output fues_pkg::cmd_entry_type head_entry,
   input  logic                    pop
);
   import fues_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_entry_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/fues_back.sv]
// Back end: expands queued commands into bus words, one per cycle while the response side accepts.
module fues_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  fues_pkg::cmd_entry_type         head_entry,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fues_pkg::OP_W-1:0]       rsp_bus_op,
   output logic [fues_pkg::BUS_ADDR_W-1:0] rsp_bus_address,
   output logic [fues_pkg::WORD_W-1:0]     rsp_bus_data,
   output logic                            rsp_last
);
   import fues_pkg::*;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]       op_ff;
   logic [BUS_ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0]     data_ff, data_in;
   logic                  last_ff;
   uop_type               uop;
   logic                  issue;

   assign uop   = fues_uop(head_entry.kind, step_ff);
   assign issue = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop   = issue && uop.last;

   always_comb begin
      case (uop.asel)
         ASEL_BLOCK: addr_in = head_entry.blk_addr;
         ASEL_AUX:   addr_in = head_entry.aux_addr;
         default:    addr_in = '0;
      endcase
      case (uop.dsel)
         DSEL_ITEM:    data_in = head_entry.data;
         DSEL_CONFIRM: data_in = CMD_CONFIRM;
         DSEL_STATUS:  data_in = CMD_STATUS;
         DSEL_ARRAY:   data_in = CMD_READ_ARRAY;
         DSEL_PROGRAM: data_in = CMD_PROGRAM;
         default:      data_in = '0;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      step_in      = step_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         step_in      = uop.last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         op_ff   <= uop.op;
         addr_ff <= addr_in;
         data_ff <= data_in;
         last_ff <= uop.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bus_op      = op_ff;
   assign rsp_bus_address = addr_ff;
   assign rsp_bus_data    = data_ff;
   assign rsp_last        = last_ff;

endmodule

[hw/rtl/flash_unlock_erase_program_sequencer.sv]
// Flash unlock, erase and program sequencer: top level.
// A start word runs the whole region: every block is unlocked and polled, then
// erased and polled, then programmed word by word from the source image, and a
// finished word closes the run. Status replies and source data come back as
// request words; flash writes, flash reads and source reads leave as response
// words, up to five for one request, the final one flagged by rsp_last. The
// front end takes one request word per cycle while its four-entry command queue
// has room; it pauses after any request that moves to another block and after
// a block_stride write, while the registered block offsets refresh. The back
// end sends one response word per cycle while rsp_ready allows; each queued
// command causes one to five such words. Registers may be rewritten between
// requests; each step uses the live values.
module flash_unlock_erase_program_sequencer #(
   parameter int ADDR_WIDTH = fues_pkg::DEF_ADDR_WIDTH,
   parameter int MAX_BLOCKS = fues_pkg::DEF_MAX_BLOCKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fues_pkg::MODE_W-1:0]      req_mode,
   input  logic [fues_pkg::WORD_W-1:0]      req_reply_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fues_pkg::OP_W-1:0]        rsp_bus_op,
   output logic [fues_pkg::BUS_ADDR_W-1:0]  rsp_bus_address,
   output logic [fues_pkg::WORD_W-1:0]      rsp_bus_data,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [fues_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fues_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import fues_pkg::*;

   logic          push_valid;
   cmd_entry_type push_entry;
   logic          queue_full;
   logic          head_valid;
   cmd_entry_type head_entry;
   logic          pop;

   fues_front #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_reply_word   (req_reply_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   fues_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   fues_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_op      (rsp_bus_op),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_data    (rsp_bus_data),
      .rsp_last        (rsp_last)
   );

endmodule
